// ===== src/clkpr_pkg.sv =====
// ----------------------------------------------------------------------------
// clkpr_pkg
// Shared types and constants of the clock page replacement unit: transaction
// payloads, opcodes, register reset value and sequencer states.
// ----------------------------------------------------------------------------
package clkpr_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int PAGE_BITS_DEF = 20;

	// fixed field widths of the transactions
	localparam int PAGE_W = 20;
	localparam int SLOT_W = 6;
	localparam int WS_W   = 7;

	localparam logic [WS_W-1:0] WS_RESET = 7'd64;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_FAULT  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [PAGE_W-1:0] page_number;
		logic [SLOT_W-1:0] slot;
		logic              is_write;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		logic              victim_valid;
		logic [PAGE_W-1:0] victim_page;
		logic              writeback;
		logic              slot_valid;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_FINISH
	} seq_state_t;

endpackage

// ===== src/clkpr_ram.sv =====
// ----------------------------------------------------------------------------
// clkpr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ----------------------------------------------------------------------------
module clkpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/clkpr_seq.sv =====
// ----------------------------------------------------------------------------
// clkpr_seq
// Sequencer of the clock replacement: decodes a transaction, runs the
// read-modify-write of the slot memory and the hand sweep, builds the result.
// ----------------------------------------------------------------------------
module clkpr_seq #(
	parameter int MAX_SLOTS = clkpr_pkg::MAX_SLOTS_DEF,
	parameter int PAGE_BITS = clkpr_pkg::PAGE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_SLOTS),
	localparam int CNT_W = $clog2(MAX_SLOTS + 1),
	localparam int ENT_W = PAGE_BITS + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clkpr_pkg::in_item_t  in_item,
	input  logic [CNT_W-1:0]     eff_size,
	output logic                 res_valid,
	input  logic                 res_ready,
	output clkpr_pkg::out_item_t res_item,
	output logic                 mem_we,
	output logic [IDX_W-1:0]     mem_waddr,
	output logic [ENT_W-1:0]     mem_wdata,
	output logic [IDX_W-1:0]     mem_raddr,
	input  logic [ENT_W-1:0]     mem_rdata
);

	localparam int CMP_W = clkpr_pkg::SLOT_W + CNT_W;

	clkpr_pkg::seq_state_t state_q, state_d;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      hand_q;
	logic [IDX_W-1:0]      pos_q;
	clkpr_pkg::in_item_t   item_q;
	clkpr_pkg::out_item_t  res_q, res_d;
	logic                  fwd_q;
	logic [ENT_W-1:0]      fwd_data_q;

	logic                  accept;
	logic                  in_filled;
	logic                  is_full;
	logic [IDX_W-1:0]      hand_start;
	logic [IDX_W-1:0]      pos_next;
	logic [ENT_W-1:0]      entry;
	logic [PAGE_BITS-1:0]  ent_page;
	logic                  ent_used;
	logic                  ent_mod;
	logic                  do_fill;
	logic                  do_start;
	logic                  do_step;
	logic                  do_victim;

	assign accept    = in_valid && in_ready;
	// slots fill in order, so a slot is filled exactly when it lies below the count
	assign in_filled = CMP_W'(in_item.slot) < CMP_W'(fill_q);
	assign is_full   = fill_q >= eff_size;
	assign hand_start = (CNT_W'(hand_q) >= fill_q) ? '0 : hand_q;
	assign pos_next  = ((CNT_W'(pos_q) + CNT_W'(1)) == fill_q) ? '0 : pos_q + IDX_W'(1);

	// forward the entry written at the edge of its read
	assign entry    = fwd_q ? fwd_data_q : mem_rdata;
	assign ent_page = entry[ENT_W-1:2];
	assign ent_used = entry[1];
	assign ent_mod  = entry[0];

	assign res_valid = (state_q == clkpr_pkg::ST_FINISH);
	assign res_item  = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			clkpr_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_item.op == clkpr_pkg::OP_ACCESS) begin
						state_d = in_filled ? clkpr_pkg::ST_ACCESS : clkpr_pkg::ST_FINISH;
					end else begin
						state_d = is_full ? clkpr_pkg::ST_SWEEP : clkpr_pkg::ST_FINISH;
					end
				end
			end
			clkpr_pkg::ST_ACCESS: begin
				state_d = clkpr_pkg::ST_FINISH;
			end
			clkpr_pkg::ST_SWEEP: begin
				if (!ent_used) begin
					state_d = clkpr_pkg::ST_FINISH;
				end
			end
			clkpr_pkg::ST_FINISH: begin
				if (res_ready) begin
					state_d = clkpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = clkpr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = entry;
		mem_raddr = pos_q;
		res_d     = res_q;
		do_fill   = 1'b0;
		do_start  = 1'b0;
		do_step   = 1'b0;
		do_victim = 1'b0;
		case (state_q)
			clkpr_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				mem_raddr = (in_item.op == clkpr_pkg::OP_ACCESS) ?
					IDX_W'(in_item.slot) : hand_start;
				if (in_valid) begin
					res_d = '0;
					if (in_item.op == clkpr_pkg::OP_ACCESS) begin
						res_d.chosen_slot = in_item.slot;
						res_d.slot_valid  = in_filled;
					end else if (!is_full) begin
						do_fill   = 1'b1;
						mem_we    = 1'b1;
						mem_waddr = IDX_W'(fill_q);
						mem_wdata = {PAGE_BITS'(in_item.page_number), 2'b00};
						res_d.chosen_slot = clkpr_pkg::SLOT_W'(fill_q);
						res_d.slot_valid  = 1'b1;
					end else begin
						do_start = 1'b1;
					end
				end
			end
			clkpr_pkg::ST_ACCESS: begin
				mem_we    = 1'b1;
				mem_waddr = IDX_W'(item_q.slot);
				mem_wdata = {ent_page, 1'b1, ent_mod | item_q.is_write};
			end
			clkpr_pkg::ST_SWEEP: begin
				mem_we = 1'b1;
				if (ent_used) begin
					// second chance: clear used and look at the next slot
					do_step   = 1'b1;
					mem_wdata = {ent_page, 1'b0, ent_mod};
					mem_raddr = pos_next;
				end else begin
					do_victim = 1'b1;
					mem_wdata = {PAGE_BITS'(item_q.page_number), 2'b00};
					res_d.chosen_slot  = clkpr_pkg::SLOT_W'(pos_q);
					res_d.victim_valid = 1'b1;
					res_d.victim_page  = clkpr_pkg::PAGE_W'(ent_page);
					res_d.writeback    = ent_mod;
					res_d.slot_valid   = 1'b1;
				end
			end
			clkpr_pkg::ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clkpr_pkg::ST_IDLE;
			fill_q  <= '0;
			hand_q  <= '0;
			fwd_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fwd_q   <= mem_we && (mem_waddr == mem_raddr);
			if (do_fill) begin
				fill_q <= fill_q + CNT_W'(1);
				if ((fill_q + CNT_W'(1)) == eff_size) begin
					hand_q <= '0;
				end
			end
			if (do_victim) begin
				hand_q <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= mem_wdata;
		res_q      <= res_d;
		if (accept) begin
			item_q <= in_item;
		end
		if (do_start) begin
			pos_q <= hand_start;
		end else if (do_step) begin
			pos_q <= pos_next;
		end
	end

endmodule

// ===== src/clock_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// clock_page_replacement_unit
// Clock (second chance) page replacement over a working set of resident pages.
// ----------------------------------------------------------------------------
// in channel: one transaction per access or page fault; an access sets the
// used bit of a filled slot (and the modified bit on a write), a fault fills
// the next free slot or evicts the first slot on the hand whose used bit is
// clear, clearing used bits on the way. out channel: one result per input.
// cfg channel: ws_size, always ready; ws_size must be written only while the
// unit is idle, which the unit itself does not enforce. Items are taken one
// at a time; the next item is taken in the cycle after the result of the last
// one moves to the output register. An eviction clears at most one used bit
// per slot of the ring. The sweep reads one slot memory entry per cycle.
// Reset empties the set, homes the hand and sets ws_size to 64; the slot
// memory needs no clearing. A stalled receiver holds the result in the
// output register; one more result waits in the sequencer, then input
// stops.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit #(
	parameter int MAX_SLOTS        = clkpr_pkg::MAX_SLOTS_DEF,
	parameter int PAGE_NUMBER_BITS = clkpr_pkg::PAGE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  clkpr_pkg::in_item_t           in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output clkpr_pkg::out_item_t          out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [clkpr_pkg::WS_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int ENT_W = PAGE_NUMBER_BITS + 2;

	logic [clkpr_pkg::WS_W-1:0] ws_size_q;
	logic [CNT_W-1:0]           eff_size;
	logic                       res_valid;
	logic                       res_ready;
	clkpr_pkg::out_item_t       res_item;
	logic                       out_valid_q;
	clkpr_pkg::out_item_t       out_item_q;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [ENT_W-1:0]           mem_wdata;
	logic [IDX_W-1:0]           mem_raddr;
	logic [ENT_W-1:0]           mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_size_q <= clkpr_pkg::WS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ws_size_q <= cfg_data;
		end
	end

	// zero acts as one, anything above the slot count as the slot count
	always_comb begin
		if (ws_size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (32'(ws_size_q) > MAX_SLOTS) begin
			eff_size = CNT_W'(MAX_SLOTS);
		end else begin
			eff_size = CNT_W'(ws_size_q);
		end
	end

	clkpr_seq #(
		.MAX_SLOTS (MAX_SLOTS),
		.PAGE_BITS (PAGE_NUMBER_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.eff_size  (eff_size),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// entry: page number, used bit, modified bit
	clkpr_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== tb/clock_page_replacement_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_page_replacement_checker
// Watches the input, result and configuration channels of the clock page
// replacement unit, keeps its own copy of the working set, predicts every
// result and compares each field of the results that come out.
// ----------------------------------------------------------------------------
module clock_page_replacement_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  clkpr_pkg::in_item_t           in_item,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  clkpr_pkg::out_item_t          out_item,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [clkpr_pkg::WS_W-1:0]    cfg_data,
	output int                            fail_count,
	output int                            outcomes_owed
);

	localparam int SLOTS = clkpr_pkg::MAX_SLOTS_DEF;

	logic [clkpr_pkg::PAGE_W-1:0] page_of [SLOTS];
	bit                           used_bit [SLOTS];
	bit                           dirty_bit [SLOTS];
	bit                           filled_bit [SLOTS];
	int unsigned                  fill_count;
	int unsigned                  hand;
	logic [clkpr_pkg::WS_W-1:0]   ws_size;
	clkpr_pkg::out_item_t         outcomes_due [$];

	task automatic report(string what);
		$display("%0t: %s", $time, what);
		fail_count++;
	endtask

	// applies one request to the working set and returns the placement it causes
	function automatic clkpr_pkg::out_item_t clock_outcome(clkpr_pkg::in_item_t req);
		clkpr_pkg::out_item_t res;
		int unsigned          eff;
		int unsigned          ring;
		int unsigned          start;
		int unsigned          pos;
		int unsigned          n;
		bit                   found;
		res = '0;
		res.slot_valid = 1'b1;
		if (req.op == clkpr_pkg::OP_ACCESS) begin
			res.chosen_slot = req.slot;
			if (filled_bit[req.slot]) begin
				used_bit[req.slot] = 1'b1;
				if (req.is_write)
					dirty_bit[req.slot] = 1'b1;
			end else begin
				res.slot_valid = 1'b0;
			end
		end else begin
			eff = (ws_size == 0) ? 1 : (ws_size > SLOTS) ? SLOTS : ws_size;
			if (fill_count < eff) begin
				res.chosen_slot = clkpr_pkg::SLOT_W'(fill_count);
				page_of[fill_count] = req.page_number;
				used_bit[fill_count] = 1'b0;
				dirty_bit[fill_count] = 1'b0;
				filled_bit[fill_count] = 1'b1;
				fill_count++;
				if (fill_count == eff)
					hand = 0;
			end else begin
				ring = fill_count;
				if (hand >= ring)
					hand = 0;
				start = hand;
				pos = start;
				found = 1'b0;
				// give each used page a second chance on the way round
				for (n = 0; n < ring && !found; n++) begin
					if (!used_bit[pos]) begin
						found = 1'b1;
					end else begin
						used_bit[pos] = 1'b0;
						pos = (pos + 1 < ring) ? pos + 1 : 0;
					end
				end
				if (!found)
					pos = start;
				res.chosen_slot = clkpr_pkg::SLOT_W'(pos);
				res.victim_valid = 1'b1;
				res.victim_page = page_of[pos];
				res.writeback = dirty_bit[pos];
				page_of[pos] = req.page_number;
				used_bit[pos] = 1'b0;
				dirty_bit[pos] = 1'b0;
				filled_bit[pos] = 1'b1;
				hand = (pos + 1 < ring) ? pos + 1 : 0;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		clkpr_pkg::out_item_t due;
		int i;
		if (!arst_n) begin
			for (i = 0; i < SLOTS; i++) begin
				used_bit[i] = 1'b0;
				dirty_bit[i] = 1'b0;
				filled_bit[i] = 1'b0;
			end
			fill_count = 0;
			hand = 0;
			ws_size = clkpr_pkg::WS_RESET;
			outcomes_due.delete();
			fail_count = 0;
			outcomes_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				ws_size = cfg_data;
			if (in_valid && in_ready)
				outcomes_due.push_back(clock_outcome(in_item));
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					report("result transaction with nothing expected");
				end else begin
					due = outcomes_due.pop_front();
					if (out_item.chosen_slot !== due.chosen_slot)
						report($sformatf("chosen_slot %0d, expected %0d",
							out_item.chosen_slot, due.chosen_slot));
					if (out_item.victim_valid !== due.victim_valid)
						report($sformatf("victim_valid %b, expected %b",
							out_item.victim_valid, due.victim_valid));
					if (out_item.victim_page !== due.victim_page)
						report($sformatf("victim_page %h, expected %h",
							out_item.victim_page, due.victim_page));
					if (out_item.writeback !== due.writeback)
						report($sformatf("writeback %b, expected %b",
							out_item.writeback, due.writeback));
					if (out_item.slot_valid !== due.slot_valid)
						report($sformatf("slot_valid %b, expected %b",
							out_item.slot_valid, due.slot_valid));
				end
			end
			outcomes_owed <= outcomes_due.size();
		end
	end

endmodule

// ===== tb/clock_page_replacement_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_page_replacement_unit_tb
// Drives accesses and page faults into the clock page replacement unit over
// a series of working set sizes and idling patterns; the checker beside the
// unit predicts and compares every result.
// ----------------------------------------------------------------------------
module clock_page_replacement_unit_tb;

	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 150;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	clkpr_pkg::in_item_t        in_item = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	clkpr_pkg::out_item_t       out_item;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [clkpr_pkg::WS_W-1:0] cfg_data = '0;

	int                         fail_count;
	int                         outcomes_owed;
	int                         quiet = 0;
	int                         send_idle = 0;
	int                         stall_pct = 0;
	int unsigned                fill_est = 0;
	logic [clkpr_pkg::WS_W-1:0] ws_now = clkpr_pkg::WS_RESET;
	logic [clkpr_pkg::WS_W-1:0] phase_ws [PHASES];

	clock_page_replacement_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	clock_page_replacement_checker check_unit (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_item       (in_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_item      (out_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outcomes_owed (outcomes_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// ends the run when no channel moves a transaction for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("clock_page_replacement_unit test failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int unsigned size_in_force(logic [clkpr_pkg::WS_W-1:0] w);
		return (w == 0) ? 1 : (w > clkpr_pkg::MAX_SLOTS_DEF) ? clkpr_pkg::MAX_SLOTS_DEF : w;
	endfunction

	function automatic clkpr_pkg::in_item_t access_item(int unsigned s, bit wr);
		clkpr_pkg::in_item_t it;
		it.op = clkpr_pkg::OP_ACCESS;
		it.page_number = clkpr_pkg::PAGE_W'($urandom_range(0, 20'hFFFFF));
		it.slot = clkpr_pkg::SLOT_W'(s);
		it.is_write = wr;
		return it;
	endfunction

	function automatic clkpr_pkg::in_item_t fault_item(logic [clkpr_pkg::PAGE_W-1:0] page);
		clkpr_pkg::in_item_t it;
		it.op = clkpr_pkg::OP_FAULT;
		it.page_number = page;
		it.slot = clkpr_pkg::SLOT_W'($urandom_range(0, 63));
		it.is_write = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// mostly accesses to resident slots so that used bits pile up before faults
	function automatic clkpr_pkg::in_item_t random_request();
		if ($urandom_range(0, 99) < 30)
			return fault_item(clkpr_pkg::PAGE_W'($urandom_range(0, 20'hFFFFF)));
		if (fill_est != 0 && $urandom_range(0, 99) < 88)
			return access_item($urandom_range(0, fill_est - 1), 1'($urandom_range(0, 1)));
		return access_item($urandom_range(0, 63), 1'($urandom_range(0, 1)));
	endfunction

	task automatic send(clkpr_pkg::in_item_t it);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (it.op == clkpr_pkg::OP_FAULT && fill_est < size_in_force(ws_now))
			fill_est++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcomes_owed != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [clkpr_pkg::WS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ws_now = value;
	endtask

	initial begin
		phase_ws = '{7'd8, 7'd0, 7'd12, 7'd1, 7'd20, 7'd33, 7'd50, 7'd64,
			7'd127, 7'd5, 7'd96, 7'd64};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small set: fill, empty slot, sweep, then every page used
		cfg_write(7'd3);
		send(fault_item(20'h00000));
		send(fault_item(20'hFFFFF));
		send(access_item(5, 1'b1));
		send(access_item(0, 1'b1));
		send(access_item(1, 1'b0));
		send(fault_item(20'h5A5A5));
		send(fault_item(20'h12345));
		send(access_item(0, 1'b1));
		send(access_item(1, 1'b1));
		send(access_item(2, 1'b1));
		send(fault_item(20'hABCDE));
		send(access_item(63, 1'b1));
		send(access_item(42, 1'b0));
		drain();
		// size raised while full
		cfg_write(7'd5);
		send(fault_item(20'h0F0F0));
		send(fault_item(20'hF0F0F));
		send(access_item(4, 1'b1));
		send(fault_item(20'h33333));
		drain();
		// size lowered while full
		cfg_write(7'd2);
		send(access_item(3, 1'b1));
		send(fault_item(20'h44444));
		send(fault_item(20'h55555));
		drain();
		cfg_write(7'd0);
		send(fault_item(20'h66666));
		drain();
		cfg_write(7'd127);
		send(fault_item(20'h77777));

		for (int p = 0; p < PHASES; p++) begin
			drain();
			cfg_write(phase_ws[p]);
			case (p % 4)
				0: begin
					send_idle = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle = 80;
					stall_pct = 0;
				end
				2: begin
					send_idle = 0;
					stall_pct = 80;
				end
				default: begin
					send_idle = 32;
					stall_pct = 32;
				end
			endcase
			repeat (PHASE_ITEMS)
				send(random_request());
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outcomes_owed == 0)
			$display("clock_page_replacement_unit test passed");
		else
			$display("clock_page_replacement_unit test failed");
		$finish;
	end

endmodule

// ===== clock_page_replacement_unit.f =====
src/clkpr_pkg.sv
src/clkpr_ram.sv
src/clkpr_seq.sv
src/clock_page_replacement_unit.sv
tb/clock_page_replacement_checker.sv
tb/clock_page_replacement_unit_tb.sv
